// ===== sv/bz_reaction_rate_terms_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the BZ reaction rate block
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef BZ_REACTION_RATE_TERMS_DEFINES_SVH
`define BZ_REACTION_RATE_TERMS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BZRT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bzrt: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define BZRT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bzrt: next-cycle check failed");

`endif

// ===== sv/bzrt_pkg.sv =====
// ----------------------------------------------------------------------------
// bzrt_pkg
// Widths, constants, types and saturation helper of the BZ rate block.
// ----------------------------------------------------------------------------
package bzrt_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 2 * DATA_W;
  localparam int COEF_W    = 31;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_DEN_W = DATA_W;
  localparam int DIV_Q_W   = DATA_W;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
  localparam int SIDE_W    = 2 * DATA_W + 8;

  localparam logic signed [DATA_W-1:0] ONE_D    = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(DATA_MAX);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(DATA_MIN);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_EPSILON = 3'd2,
    REG_MU      = 3'd3,
    REG_Q       = 3'd4,
    REG_XCUR    = 3'd5,
    REG_ZCUR    = 3'd6
  } cfg_reg_e;

  localparam logic [COEF_W-1:0] ALPHA_RST   = 31'd7134;
  localparam logic [COEF_W-1:0] BETA_RST    = 31'd250;
  localparam logic [COEF_W-1:0] EPSILON_RST = 31'd19520794;
  localparam logic [COEF_W-1:0] MU_RST      = 31'd4274;
  localparam logic [COEF_W-1:0] Q_RST       = 31'd10066330;

  typedef struct packed {
    logic [COEF_W-1:0]        alpha;
    logic [COEF_W-1:0]        beta;
    logic [COEF_W-1:0]        eps;
    logic [COEF_W-1:0]        mu;
    logic [COEF_W-1:0]        q;
    logic signed [DATA_W-1:0] ix;
    logic signed [DATA_W-1:0] iz;
  } coef_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dz;
    logic                     in_domain;
  } res_t;

  // Clamp a wide signed value to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] a);
    logic signed [DATA_W-1:0] r;
    if (a > WIDE_MAX) begin
      r = DATA_MAX;
    end else if (a < WIDE_MIN) begin
      r = DATA_MIN;
    end else begin
      r = a[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/bz_reaction_rate_terms.sv =====
// ----------------------------------------------------------------------------
// bz_reaction_rate_terms
// Rate terms of the two-variable Belousov-Zhabotinsky model, one point/cycle unless stalled.
// ----------------------------------------------------------------------------
// The block accepts one grid point (x, z) per clock while in_stall is low
// and returns one item holding dx, dz and an in-domain flag for each; the
// path runs through three 32-stage restoring divider pipelines
// (v = alpha*z/(1-z), the (x-mu)/(x+mu) term and the division by epsilon),
// one quotient bit each stage. When x <= mu or z >= 1 the item comes out
// with in_domain low and both rates zero. All values are signed Q8.24,
// every intermediate is truncated toward zero and saturated to 32 bits.
// The user must write coefficients through the cfg port only while no item
// is in flight; the block itself does not enforce this.
module bz_reaction_rate_terms (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bzrt_pkg::DATA_W-1:0]  in_x_value,
  input  logic signed [bzrt_pkg::DATA_W-1:0]  in_z_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bzrt_pkg::DATA_W-1:0]  out_dx_rate,
  output logic signed [bzrt_pkg::DATA_W-1:0]  out_dz_rate,
  output logic                                out_in_domain,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bzrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bzrt_pkg::DATA_W-1:0]         cfg_wdata
);
  import bzrt_pkg::*;

  localparam int PAD_W = SIDE_W - 2 * DATA_W - 2;
  localparam int PAD3_W = SIDE_W - DATA_W - 3;

  // Signed shift right that rounds toward zero, as a C division would.
  function automatic logic signed [WIDE_W-1:0] trunc_shift(input logic signed [WIDE_W-1:0] a,
                                                          input int unsigned sh);
    logic signed [WIDE_W-1:0] bias;
    bias = a[WIDE_W-1] ? ((WIDE_W'(1) <<< sh) - WIDE_W'(1)) : '0;
    return (a + bias) >>> sh;
  endfunction

  // Quotient magnitude; an overflowed divider stands for anything past range.
  function automatic logic [DATA_W:0] mag_of(input logic ovf, input logic [DATA_W-1:0] quo);
    return ovf ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quo};
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_sign(input logic [DATA_W:0] mag,
                                                         input logic neg);
    logic signed [WIDE_W-1:0] w;
    w = $signed(WIDE_W'(mag));
    if (neg) begin
      w = -w;
    end
    return sat_data(w);
  endfunction

  coef_t coef;
  logic  en;
  res_t  res_nxt;
  res_t  out_res;

  logic signed [DATA_W-1:0] alpha_s, beta_s, q_s, mu_s;
  assign alpha_s = $signed({1'b0, coef.alpha});
  assign beta_s  = $signed({1'b0, coef.beta});
  assign q_s     = $signed({1'b0, coef.q});
  assign mu_s    = $signed({1'b0, coef.mu});

  // The whole pipeline moves together; it halts only while the skid entry of
  // the output buffer is occupied.
  assign in_stall = !en;

  bzrt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // Stage 1: capture the item.
  logic                     s1_v_r;
  logic signed [DATA_W-1:0] s1_x_r, s1_z_r;

  // Stage 2: alpha*z and x*(1-x) products, 1-z denominator, domain check.
  logic                     s2_v_r, s2_ood_r;
  logic signed [DATA_W-1:0] s2_x_r;
  logic signed [WIDE_W-1:0] s2_az_r, s2_px_r;
  logic [DATA_W-1:0]        s2_d1_r;
  logic signed [DATA_W:0]   omx, d1w;
  logic signed [WIDE_W-1:0] az_nxt, px_nxt;

  assign omx    = (DATA_W+1)'(ONE_D) - (DATA_W+1)'(s1_x_r);
  assign d1w    = (DATA_W+1)'(ONE_D) - (DATA_W+1)'(s1_z_r);
  assign az_nxt = alpha_s * s1_z_r;
  assign px_nxt = omx * s1_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r   <= in_x_value;
      s1_z_r   <= in_z_value;
      s2_x_r   <= s1_x_r;
      s2_ood_r <= (s1_x_r <= mu_s) || (s1_z_r >= ONE_D);
      s2_az_r  <= az_nxt;
      s2_px_r  <= px_nxt;
      s2_d1_r  <= d1w[DATA_W-1:0];
    end
  end

  // First divider: |alpha*z| / (1-z). The product x*(1-x) is scaled here and
  // rides along as sideband.
  logic                     neg1;
  logic [WIDE_W-1:0]        num1;
  logic signed [DATA_W-1:0] p1;
  logic [SIDE_W-1:0]        side1_in;
  logic                     d1_v, d1_ovf;
  logic [DATA_W-1:0]        d1_quo;
  logic [SIDE_W-1:0]        d1_side;

  assign neg1     = s2_az_r[WIDE_W-1];
  assign num1     = neg1 ? -s2_az_r : s2_az_r;
  assign p1       = sat_data(trunc_shift(s2_px_r, FRAC_BITS));
  assign side1_in = {{PAD_W{1'b0}}, s2_ood_r, neg1, p1, s2_x_r};

  bzrt_div u_div_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_num    (num1),
    .in_den    (s2_d1_r),
    .in_side   (side1_in),
    .out_valid (d1_v),
    .out_quo   (d1_quo),
    .out_ovf   (d1_ovf),
    .out_side  (d1_side)
  );

  // Stage 4: signed, saturated v.
  logic                     s4_v_r, s4_ood_r;
  logic signed [DATA_W-1:0] s4_x_r, s4_p_r, s4_vv_r;

  // Stage 5: q*v product, dz, and the x-mu / x+mu pair.
  logic                     s5_v_r, s5_ood_r;
  logic signed [WIDE_W-1:0] s5_qv_r;
  logic signed [DATA_W-1:0] s5_dz_r, s5_p_r, s5_xmm_r;
  logic [DATA_W-1:0]        s5_xpm_r;
  logic signed [DATA_W+1:0] dzw;
  logic signed [DATA_W:0]   xpw;

  assign dzw = (DATA_W+2)'(s4_x_r) - (DATA_W+2)'(s4_vv_r) + (DATA_W+2)'(coef.iz);
  assign xpw = (DATA_W+1)'(s4_x_r) + (DATA_W+1)'(mu_s);

  // Stage 6: g = 2*q*v + beta.
  logic                     s6_v_r, s6_ood_r;
  logic signed [DATA_W-1:0] s6_g_r, s6_dz_r, s6_p_r, s6_xmm_r;
  logic [DATA_W-1:0]        s6_xpm_r;

  // Stage 7: g*(x-mu).
  logic                     s7_v_r, s7_ood_r;
  logic signed [WIDE_W-1:0] s7_gm_r;
  logic signed [DATA_W-1:0] s7_dz_r, s7_p_r;
  logic [DATA_W-1:0]        s7_xpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= d1_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x_r   <= d1_side[DATA_W-1:0];
      s4_p_r   <= d1_side[2*DATA_W-1:DATA_W];
      s4_ood_r <= d1_side[2*DATA_W+1];
      s4_vv_r  <= apply_sign(mag_of(d1_ovf, d1_quo), d1_side[2*DATA_W]);

      s5_ood_r <= s4_ood_r;
      s5_qv_r  <= q_s * s4_vv_r;
      s5_dz_r  <= sat_data(WIDE_W'(dzw));
      s5_p_r   <= s4_p_r;
      s5_xmm_r <= s4_x_r - mu_s;
      s5_xpm_r <= xpw[DATA_W-1:0];

      s6_ood_r <= s5_ood_r;
      s6_g_r   <= sat_data(trunc_shift(s5_qv_r, FRAC_BITS - 1) + WIDE_W'(beta_s));
      s6_dz_r  <= s5_dz_r;
      s6_p_r   <= s5_p_r;
      s6_xmm_r <= s5_xmm_r;
      s6_xpm_r <= s5_xpm_r;

      s7_ood_r <= s6_ood_r;
      s7_gm_r  <= s6_g_r * s6_xmm_r;
      s7_dz_r  <= s6_dz_r;
      s7_p_r   <= s6_p_r;
      s7_xpm_r <= s6_xpm_r;
    end
  end

  // Second divider: |g*(x-mu)| / (x+mu); for in-domain points the quotient never exceeds |g|.
  logic              neg2;
  logic [WIDE_W-1:0] num2;
  logic [SIDE_W-1:0] side2_in;
  logic              d2_v, d2_ovf;
  logic [DATA_W-1:0] d2_quo;
  logic [SIDE_W-1:0] d2_side;

  assign neg2     = s7_gm_r[WIDE_W-1];
  assign num2     = neg2 ? -s7_gm_r : s7_gm_r;
  assign side2_in = {{PAD_W{1'b0}}, s7_ood_r, neg2, s7_dz_r, s7_p_r};

  bzrt_div u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_num    (num2),
    .in_den    (s7_xpm_r),
    .in_side   (side2_in),
    .out_valid (d2_v),
    .out_quo   (d2_quo),
    .out_ovf   (d2_ovf),
    .out_side  (d2_side)
  );

  // Stage 8: n = p - t.
  logic                     s8_v_r, s8_ood_r;
  logic signed [DATA_W-1:0] s8_n_r, s8_dz_r;
  logic signed [DATA_W-1:0] t_val;

  assign t_val = apply_sign(mag_of(d2_ovf, d2_quo), d2_side[2*DATA_W]);

  // Third divider: |n| * 2^FRAC_BITS / epsilon. A zero epsilon overflows the
  // divider and so saturates with the sign of n; a zero n is forced to zero.
  logic              negn, zn;
  logic [DATA_W-1:0] absn;
  logic [WIDE_W-1:0] num3;
  logic [SIDE_W-1:0] side3_in;
  logic              d3_v, d3_ovf;
  logic [DATA_W-1:0] d3_quo;
  logic [SIDE_W-1:0] d3_side;

  assign negn     = s8_n_r[DATA_W-1];
  assign zn       = (s8_n_r == '0);
  assign absn     = negn ? -s8_n_r : s8_n_r;
  assign num3     = WIDE_W'(absn) << FRAC_BITS;
  assign side3_in = {{PAD3_W{1'b0}}, s8_ood_r, negn, zn, s8_dz_r};

  bzrt_div u_div_eps (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_v_r),
    .in_num    (num3),
    .in_den    ({1'b0, coef.eps}),
    .in_side   (side3_in),
    .out_valid (d3_v),
    .out_quo   (d3_quo),
    .out_ovf   (d3_ovf),
    .out_side  (d3_side)
  );

  // Stage 9: scaled dx before the current is added.
  logic                     s9_v_r, s9_ood_r;
  logic signed [DATA_W-1:0] s9_dq_r, s9_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= d2_v;
      s9_v_r <= d3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ood_r <= d2_side[2*DATA_W+1];
      s8_dz_r  <= d2_side[2*DATA_W-1:DATA_W];
      s8_n_r   <= sat_data(WIDE_W'($signed(d2_side[DATA_W-1:0])) - WIDE_W'(t_val));

      s9_ood_r <= d3_side[DATA_W+2];
      s9_dz_r  <= d3_side[DATA_W-1:0];
      s9_dq_r  <= d3_side[DATA_W] ? '0
                                  : apply_sign(mag_of(d3_ovf, d3_quo), d3_side[DATA_W+1]);
    end
  end

  // Add the x current and blank out-of-domain points.
  always_comb begin
    if (s9_ood_r) begin
      res_nxt.dx        = '0;
      res_nxt.dz        = '0;
      res_nxt.in_domain = 1'b0;
    end else begin
      res_nxt.dx        = sat_data(WIDE_W'(s9_dq_r) + WIDE_W'(coef.ix));
      res_nxt.dz        = s9_dz_r;
      res_nxt.in_domain = 1'b1;
    end
  end

  bzrt_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (s9_v_r),
    .pipe_res   (res_nxt),
    .out_stall  (out_stall),
    .en         (en),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_dx_rate   = out_res.dx;
  assign out_dz_rate   = out_res.dz;
  assign out_in_domain = out_res.in_domain;

endmodule

// ===== sv/bzrt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bzrt_cfg_regs
// Coefficient and current registers written through the configuration port.
// ----------------------------------------------------------------------------
module bzrt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bzrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bzrt_pkg::DATA_W-1:0]        cfg_wdata,
  output bzrt_pkg::coef_t                    coef
);
  import bzrt_pkg::*;

  coef_t coef_r;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.alpha <= ALPHA_RST;
      coef_r.beta  <= BETA_RST;
      coef_r.eps   <= EPSILON_RST;
      coef_r.mu    <= MU_RST;
      coef_r.q     <= Q_RST;
      coef_r.ix    <= '0;
      coef_r.iz    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ALPHA:   coef_r.alpha <= cfg_wdata[COEF_W-1:0];
        REG_BETA:    coef_r.beta  <= cfg_wdata[COEF_W-1:0];
        REG_EPSILON: coef_r.eps   <= cfg_wdata[COEF_W-1:0];
        REG_MU:      coef_r.mu    <= cfg_wdata[COEF_W-1:0];
        REG_Q:       coef_r.q     <= cfg_wdata[COEF_W-1:0];
        REG_XCUR:    coef_r.ix    <= $signed(cfg_wdata);
        REG_ZCUR:    coef_r.iz    <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/bzrt_div.sv =====
// ----------------------------------------------------------------------------
// bzrt_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bzrt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [bzrt_pkg::DIV_NUM_W-1:0] in_num,
  input  logic [bzrt_pkg::DIV_DEN_W-1:0] in_den,
  input  logic [bzrt_pkg::SIDE_W-1:0]    in_side,
  output logic                           out_valid,
  output logic [bzrt_pkg::DIV_Q_W-1:0]   out_quo,
  output logic                           out_ovf,
  output logic [bzrt_pkg::SIDE_W-1:0]    out_side
);
  import bzrt_pkg::*;

  // acc holds the partial remainder on top and the numerator bits still to be
  // consumed below it; quotient bits shift in at the bottom.
  typedef struct packed {
    logic [DIV_NUM_W-1:0] acc;
    logic [DIV_DEN_W-1:0] den;
    logic                 ovf;
    logic [SIDE_W-1:0]    side;
  } div_stage_t;

  logic       vld_r [0:DIV_Q_W];
  div_stage_t stg_r [0:DIV_Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].acc  <= in_num;
      stg_r[0].den  <= in_den;
      stg_r[0].ovf  <= (in_num[DIV_NUM_W-1:DIV_Q_W] >= in_den);
      stg_r[0].side <= in_side;
    end
  end

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [DIV_DEN_W:0]   top;
    logic [DIV_DEN_W+1:0] diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] rem_nxt;

    assign top     = stg_r[k].acc[DIV_NUM_W-1:DIV_Q_W-1];
    assign diff    = {1'b0, top} - {2'b00, stg_r[k].den};
    assign ge      = !diff[DIV_DEN_W+1];
    assign rem_nxt = ge ? diff[DIV_DEN_W-1:0] : top[DIV_DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1].acc  <= {rem_nxt, stg_r[k].acc[DIV_Q_W-2:0], ge};
        stg_r[k+1].den  <= stg_r[k].den;
        stg_r[k+1].ovf  <= stg_r[k].ovf;
        stg_r[k+1].side <= stg_r[k].side;
      end
    end
  end

  assign out_valid = vld_r[DIV_Q_W];
  assign out_quo   = stg_r[DIV_Q_W].acc[DIV_Q_W-1:0];
  assign out_ovf   = stg_r[DIV_Q_W].ovf;
  assign out_side  = stg_r[DIV_Q_W].side;

endmodule

// ===== sv/bzrt_out_buf.sv =====
// ----------------------------------------------------------------------------
// bzrt_out_buf
// Output register with a skid entry; decouples the pipeline from out_stall.
// ----------------------------------------------------------------------------
`include "bz_reaction_rate_terms_defines.svh"

module bzrt_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pipe_valid,
  input  bzrt_pkg::res_t  pipe_res,
  input  logic            out_stall,
  output logic            en,
  output logic            out_valid,
  output bzrt_pkg::res_t  out_res
);
  import bzrt_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;
  logic pop;
  logic skid_fill;

  assign pop       = out_valid_r && !out_stall;
  assign en        = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign skid_fill = pipe_valid && !skid_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (pipe_valid) begin
      if (!out_valid_r || pop) begin
        out_res_r <= pipe_res;
      end else begin
        skid_res_r <= pipe_res;
      end
    end
  end

  `BZRT_ASSERT_IMPL(a_skid_implies_out, clk, rst_n, skid_valid_r, out_valid_r)
  `BZRT_ASSERT_NEXT(a_skid_fills, clk, rst_n, skid_fill, skid_valid_r)
  `BZRT_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r)

endmodule

// ===== verif/bz_reaction_rate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BZ rate term checker
// Watches the item, result and coefficient channels of the rate block,
// computes the expected rates of each accepted point and compares them with
// the results in order.
// ----------------------------------------------------------------------------
module bz_reaction_rate_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [bzrt_pkg::DATA_W-1:0] in_x_value,
  input  logic signed [bzrt_pkg::DATA_W-1:0] in_z_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [bzrt_pkg::DATA_W-1:0] out_dx_rate,
  input  logic signed [bzrt_pkg::DATA_W-1:0] out_dz_rate,
  input  logic                               out_in_domain,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [bzrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bzrt_pkg::DATA_W-1:0]        cfg_wdata,
  output int                                 mismatches,
  output int                                 rates_pending
);
  import bzrt_pkg::*;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam longint LIM_L = longint'(1) << (DATA_W - 1);

  coef_t coefs;
  res_t  rates_due[$];

  function automatic longint clamp_data(input longint a);
    if (a > LIM_L - 1) return LIM_L - 1;
    if (a < -LIM_L) return -LIM_L;
    return a;
  endfunction

  // Restoring division of n * 2^FRAC_BITS by d, capped once it passes cap.
  function automatic longint unsigned scaled_quotient(input longint unsigned n,
                                                      input longint unsigned d,
                                                      input longint unsigned cap);
    longint unsigned qt;
    longint unsigned rm;
    qt = n / d;
    rm = n % d;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (qt > cap) return cap;
      qt = qt << 1;
      rm = rm << 1;
      if (rm >= d) begin
        rm = rm - d;
        qt = qt + 1;
      end
    end
    return (qt > cap) ? cap : qt;
  endfunction

  function automatic res_t predict_rates(input logic signed [DATA_W-1:0] xv,
                                         input logic signed [DATA_W-1:0] zv);
    res_t   r;
    longint x, z, mu, v, omx, p, g, t, n, dq;
    longint unsigned mag;
    x  = longint'(xv);
    z  = longint'(zv);
    mu = longint'(coefs.mu);
    r  = '0;
    if (x <= mu || z >= ONE_L) return r;
    v   = clamp_data((longint'(coefs.alpha) * z) / (ONE_L - z));
    omx = clamp_data(ONE_L - x);
    p   = clamp_data((x * omx) / ONE_L);
    g   = clamp_data((longint'(coefs.q) * v) / (longint'(1) << (FRAC_BITS - 1))
                     + longint'(coefs.beta));
    t   = (g * (x - mu)) / (x + mu);
    n   = clamp_data(p - t);
    if (n == 0) begin
      dq = 0;
    end else if (coefs.eps == 0) begin
      dq = (n > 0) ? LIM_L - 1 : -LIM_L;
    end else begin
      mag = scaled_quotient((n < 0) ? -n : n, longint'(coefs.eps), LIM_L);
      dq  = clamp_data((n < 0) ? -longint'(mag) : longint'(mag));
    end
    r.dx        = DATA_W'(clamp_data(dq + longint'(coefs.ix)));
    r.dz        = DATA_W'(clamp_data(x - v + longint'(coefs.iz)));
    r.in_domain = 1'b1;
    return r;
  endfunction

  assign rates_pending = rates_due.size();

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      coefs.alpha <= ALPHA_RST;
      coefs.beta  <= BETA_RST;
      coefs.eps   <= EPSILON_RST;
      coefs.mu    <= MU_RST;
      coefs.q     <= Q_RST;
      coefs.ix    <= '0;
      coefs.iz    <= '0;
      rates_due.delete();
      mismatches  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_ALPHA:   coefs.alpha <= cfg_wdata[COEF_W-1:0];
          REG_BETA:    coefs.beta  <= cfg_wdata[COEF_W-1:0];
          REG_EPSILON: coefs.eps   <= cfg_wdata[COEF_W-1:0];
          REG_MU:      coefs.mu    <= cfg_wdata[COEF_W-1:0];
          REG_Q:       coefs.q     <= cfg_wdata[COEF_W-1:0];
          REG_XCUR:    coefs.ix    <= cfg_wdata;
          REG_ZCUR:    coefs.iz    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) rates_due.push_back(predict_rates(in_x_value, in_z_value));
      if (out_valid && !out_stall) begin
        if (rates_due.size() == 0) begin
          $display("%0t: expected no result, got dx=%0d dz=%0d in_domain=%0b", $time,
                   out_dx_rate, out_dz_rate, out_in_domain);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = rates_due.pop_front();
          if (out_dx_rate !== exp_r.dx || out_dz_rate !== exp_r.dz ||
              out_in_domain !== exp_r.in_domain) begin
            $display("%0t: expected dx=%0d dz=%0d dom=%0b, got dx=%0d dz=%0d dom=%0b",
                     $time, exp_r.dx, exp_r.dz, exp_r.in_domain,
                     out_dx_rate, out_dz_rate, out_in_domain);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_bz_reaction_rate_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BZ rate term testbench
// Feeds grid points to the rate block under several coefficient sets, with
// random gaps and back pressure, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb_bz_reaction_rate_terms;
  import bzrt_pkg::*;

  localparam int     MAX_CYCLES = 2000000;
  localparam int     DRAIN_WAIT = 120;   // idle wait before the final verdict
  localparam logic [DATA_W-1:0] C31_MAX = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [DATA_W-1:0] in_x_value = '0;
  logic signed [DATA_W-1:0] in_z_value = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic in_stall, out_valid, out_in_domain, cfg_ready;
  logic signed [DATA_W-1:0] out_dx_rate, out_dz_rate;
  int mismatches, rates_pending;
  int cycle_count = 0;

  // Mirror of mu so that the stimulus can aim at the domain edge.
  longint cur_mu = MU_RST;
  // When set, the sender never idles, giving stretches of full rate.
  bit no_gaps = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bz_reaction_rate_terms u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_x_value, .in_z_value,
    .out_valid, .out_stall, .out_dx_rate, .out_dz_rate, .out_in_domain,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  bz_reaction_rate_checker u_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_x_value, .in_z_value,
    .out_valid, .out_stall, .out_dx_rate, .out_dz_rate, .out_in_domain,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .mismatches, .rates_pending
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // The result side holds stall for a random run, then picks again. Some runs
  // are long open stretches so that results can drain at full rate.
  int stall_hold = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_hold == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(50, 200);
      end else begin
        out_stall  <= ($urandom_range(0, 2) == 0);
        stall_hold <= pick_gap();
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  // A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("tb_bz_reaction_rate_terms: FAIL");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MU) cur_mu = longint'(val[COEF_W-1:0]);
  endtask

  task automatic load_coefs(input logic [DATA_W-1:0] a, b, e, m, q, ix, iz);
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, b);
    write_reg(REG_EPSILON, e);
    write_reg(REG_MU, m);
    write_reg(REG_Q, q);
    write_reg(REG_XCUR, ix);
    write_reg(REG_ZCUR, iz);
    cfg_valid <= 1'b0;
  endtask

  // One item: an optional idle gap, then hold it until the block takes it.
  task automatic send_point(input logic signed [DATA_W-1:0] x, z);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_value <= x;
    in_z_value <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    while (rates_pending != 0) @(posedge clk);
  endtask

  // Edge points: the domain boundary on both x and z, the field extremes
  // and a few ordinary points.
  task automatic send_edges();
    longint m;
    m = cur_mu;
    send_point(DATA_W'(m), 0);
    send_point(DATA_W'(m + 1), 0);
    send_point(DATA_W'(m + 1), ONE_D - 1);
    send_point(ONE_D >>> 1, ONE_D);
    send_point(ONE_D >>> 1, ONE_D - 1);
    send_point(ONE_D >>> 1, DATA_MIN);
    send_point(ONE_D >>> 1, 0);
    send_point(ONE_D, ONE_D >>> 1);
    send_point(DATA_MAX, 0);
    send_point(DATA_MAX, ONE_D - 1);
    send_point(DATA_MAX, DATA_MIN);
    send_point(DATA_MIN, DATA_MIN);
    send_point(DATA_MAX, DATA_MAX);
    send_point(0, 0);
  endtask

  // Random points: mostly inside the domain with realistic magnitudes, some
  // at the boundary and some with every bit free.
  task automatic send_random(input int count);
    logic signed [DATA_W-1:0] x, z;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        x = DATA_W'(cur_mu + 1 + $urandom_range(0, 32'h0200_0000));
        z = ($urandom_range(0, 3) == 0) ? -DATA_W'($urandom_range(0, 32'h0100_0000))
                                        : DATA_W'($urandom_range(0, ONE_D - 1));
        if (cur_mu > 32'h0200_0000) x = DATA_W'($urandom());
      end else if (r < 85) begin
        x = $urandom();
        z = $urandom();
      end else begin
        x = DATA_W'(cur_mu + $urandom_range(0, 1));
        z = ONE_D - $urandom_range(0, 1);
      end
      send_point(x, z);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients.
    send_edges();
    send_random(100);
    end_burst();

    // Largest coefficients, zero epsilon, smallest mu, extreme currents.
    load_coefs(C31_MAX, C31_MAX, 0, 1, C31_MAX, DATA_MAX, DATA_MIN);
    send_edges();
    send_random(100);
    end_burst();

    // Smallest coefficients with the largest mu, so nearly all points fall out.
    load_coefs(1, 1, 1, C31_MAX, 1, DATA_MIN, DATA_MAX);
    send_edges();
    send_random(60);
    end_burst();

    // Zero coefficients are used as written.
    load_coefs(0, 0, 0, 0, 0, 0, 0);
    send_edges();
    send_random(60);
    end_burst();

    // Reset values again with random currents, part of it at full rate.
    load_coefs(ALPHA_RST, BETA_RST, EPSILON_RST, MU_RST, Q_RST, $urandom(), $urandom());
    no_gaps = 1'b1;
    send_random(300);
    no_gaps = 1'b0;
    send_random(300);
    end_burst();

    // Random coefficient sets of realistic size.
    for (int k = 0; k < 4; k++) begin
      load_coefs($urandom_range(1, ONE_D), $urandom_range(1, ONE_D),
                 $urandom_range(32'h0010_0000, 32'h0400_0000), $urandom_range(1, 32'h0010_0000),
                 $urandom_range(1, 32'h0200_0000), $urandom(), $urandom());
      send_random(200);
      end_burst();
    end

    // Fully random coefficient words.
    for (int k = 0; k < 2; k++) begin
      load_coefs($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h0100_0000),
                 $urandom(), $urandom(), $urandom());
      send_edges();
      send_random(200);
      end_burst();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && rates_pending == 0) begin
      $display("tb_bz_reaction_rate_terms: PASS");
    end else begin
      $display("tb_bz_reaction_rate_terms: FAIL");
    end
    $finish;
  end

endmodule
